// ===== sv/modexp_pkg.sv =====
// ----------------------------------------------------------------------------
// Modular exponentiation package
// Shared field width and the payload types of the input and result channels.
// ----------------------------------------------------------------------------
package modexp_pkg;

  localparam int FIELD_W = 32;

  typedef struct packed {
    logic [FIELD_W-1:0] base;
    logic [FIELD_W-1:0] exponent;
  } in_item_t;

  typedef struct packed {
    logic [FIELD_W-1:0] power_mod;
  } out_item_t;

endpackage

// ===== sv/modexp_stream_if.sv =====
// ----------------------------------------------------------------------------
// Valid/ready stream interface
// One channel carrying valid, ready and a payload of a chosen type.
// ----------------------------------------------------------------------------
interface modexp_stream_if #(
  parameter type data_t = logic
);

  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

// ===== sv/modexp_mulmod.sv =====
// ----------------------------------------------------------------------------
// Bit-serial modular multiplier
// Computes a * b mod m by scanning b from its top bit, one bit per cycle,
// doubling the partial result and adding a, with a three-way reduction.
// ----------------------------------------------------------------------------
module modexp_mulmod #(
  parameter int WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [WIDTH-1:0] a,
  input  logic [WIDTH-1:0] b,
  input  logic [WIDTH:0]   m,
  output logic             done,
  output logic [WIDTH-1:0] result
);

  localparam int CW = $clog2(WIDTH);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [WIDTH-1:0] a_r, a_nxt;
  logic [WIDTH-1:0] b_r, b_nxt;
  logic [WIDTH-1:0] r_r, r_nxt;
  logic [WIDTH+1:0] sum, m1, m2, d1, d2;
  logic [WIDTH-1:0] r_step;

  always_comb begin
    m1  = {1'b0, m};
    m2  = {m, 1'b0};
    sum = {1'b0, r_r, 1'b0} + (b_r[WIDTH-1] ? {2'b00, a_r} : '0);
    d1  = sum - m1;
    d2  = sum - m2;
    if (sum >= m2) begin
      r_step = d2[WIDTH-1:0];
    end else if (sum >= m1) begin
      r_step = d1[WIDTH-1:0];
    end else begin
      r_step = sum[WIDTH-1:0];
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    r_nxt    = r_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      a_nxt    = a;
      b_nxt    = b;
      r_nxt    = '0;
    end else if (busy_r) begin
      r_nxt   = r_step;
      b_nxt   = b_r << 1;
      cnt_nxt = cnt_r + CW'(1);
      if (cnt_r == CW'(WIDTH - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r <= a_nxt;
    b_r <= b_nxt;
    r_r <= r_nxt;
  end

  assign done   = done_r;
  assign result = r_r;

endmodule

// ===== sv/modular_exponentiation_top.sv =====
// ----------------------------------------------------------------------------
// Modular exponentiation top level
// Returns base to the exponent modulo the configured modulus, one result per
// input transfer, by right-to-left square-and-multiply.
// ----------------------------------------------------------------------------
// One item is worked at a time on a single bit-serial modular multiplier. An
// item takes 1 + h + k products, where h is the position of the highest set
// exponent bit and k the number of set exponent bits; the leading product
// reduces the base. An exponent of zero returns 1. A modulus of zero acts as
// 2 to the power WIDTH. The input is ready again while a result still waits
// in the output register. The modulus may only be written while idle.
module modular_exponentiation_top #(
  parameter int WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [modexp_pkg::FIELD_W-1:0] cfg_wdata,
  modexp_stream_if.sink                 in_if,
  modexp_stream_if.source               out_if
);

  import modexp_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_REDUCE = 6'b000010,
    ST_STEP   = 6'b000100,
    ST_MUL    = 6'b001000,
    ST_SQR    = 6'b010000,
    ST_DONE   = 6'b100000
  } state_t;

  state_t               state_r, state_nxt;
  logic [FIELD_W-1:0]   mod_r, mod_nxt;
  logic [WIDTH:0]       mod_ext_r, mod_ext_nxt;
  logic [WIDTH-1:0]     acc_r, acc_nxt;
  logic [WIDTH-1:0]     b_r, b_nxt;
  logic [WIDTH-1:0]     e_r, e_nxt;
  logic                 start_r, start_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [FIELD_W-1:0]   out_data_r, out_data_nxt;

  logic [WIDTH+FIELD_W-1:0] mod_pad, base_pad, exp_pad, acc_pad;
  logic [WIDTH-1:0]     mod_w, base_w, exp_w;
  logic [WIDTH-1:0]     mm_a;
  logic                 mm_done;
  logic [WIDTH-1:0]     mm_result;
  logic                 in_xfer;

  assign mod_pad  = {{WIDTH{1'b0}}, mod_r};
  assign base_pad = {{WIDTH{1'b0}}, in_if.data.base};
  assign exp_pad  = {{WIDTH{1'b0}}, in_if.data.exponent};
  assign acc_pad  = {{FIELD_W{1'b0}}, acc_r};
  assign mod_w    = mod_pad[WIDTH-1:0];
  assign base_w   = base_pad[WIDTH-1:0];
  assign exp_w    = exp_pad[WIDTH-1:0];

  assign in_if.ready = (state_r == ST_IDLE);
  assign in_xfer     = in_if.valid && in_if.ready;

  always_comb begin
    unique case (state_r)
      ST_REDUCE: mm_a = {{(WIDTH-1){1'b0}}, 1'b1};
      ST_MUL:    mm_a = acc_r;
      default:   mm_a = b_r;
    endcase
  end

  modexp_mulmod #(
    .WIDTH(WIDTH)
  ) u_mulmod (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start_r),
    .a      (mm_a),
    .b      (b_r),
    .m      (mod_ext_r),
    .done   (mm_done),
    .result (mm_result)
  );

  always_comb begin
    state_nxt     = state_r;
    mod_nxt       = mod_r;
    mod_ext_nxt   = mod_ext_r;
    acc_nxt       = acc_r;
    b_nxt         = b_r;
    e_nxt         = e_r;
    start_nxt     = 1'b0;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (cfg_we) begin
      mod_nxt = cfg_wdata;
    end
    if (out_valid_r && out_if.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          mod_ext_nxt = (mod_w == '0) ? {1'b1, {WIDTH{1'b0}}} : {1'b0, mod_w};
          b_nxt       = base_w;
          e_nxt       = exp_w;
          if (exp_w == '0) begin
            acc_nxt   = {{(WIDTH-1){1'b0}}, 1'b1};
            state_nxt = ST_DONE;
          end else begin
            acc_nxt   = {{(WIDTH-1){1'b0}}, (mod_w != {{(WIDTH-1){1'b0}}, 1'b1})};
            start_nxt = 1'b1;
            state_nxt = ST_REDUCE;
          end
        end
      end
      ST_REDUCE: begin
        if (mm_done) begin
          b_nxt     = mm_result;
          state_nxt = ST_STEP;
        end
      end
      ST_STEP: begin
        start_nxt = 1'b1;
        state_nxt = e_r[0] ? ST_MUL : ST_SQR;
      end
      ST_MUL: begin
        if (mm_done) begin
          acc_nxt = mm_result;
          if ((e_r >> 1) == '0) begin
            state_nxt = ST_DONE;
          end else begin
            start_nxt = 1'b1;
            state_nxt = ST_SQR;
          end
        end
      end
      ST_SQR: begin
        if (mm_done) begin
          b_nxt     = mm_result;
          e_nxt     = e_r >> 1;
          state_nxt = ST_STEP;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_if.ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = acc_pad[FIELD_W-1:0];
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mod_r       <= FIELD_W'(1);
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mod_r       <= mod_nxt;
      start_r     <= start_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mod_ext_r  <= mod_ext_nxt;
    acc_r      <= acc_nxt;
    b_r        <= b_nxt;
    e_r        <= e_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_if.valid          = out_valid_r;
  assign out_if.data.power_mod = out_data_r;

`ifndef SYNTHESIS
  a_done_in_op: assert property (@(posedge clk) disable iff (!rst_n)
    mm_done |-> (state_r == ST_REDUCE || state_r == ST_MUL || state_r == ST_SQR))
    else $error("multiplier finished outside a product state");

  a_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_STEP) |-> ({1'b0, acc_r} < mod_ext_r && {1'b0, b_r} < mod_ext_r))
    else $error("operand not reduced below the modulus");

  a_zero_exp: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && exp_w == '0) |=> (state_r == ST_DONE && acc_r == WIDTH'(1)))
    else $error("zero exponent did not go straight to the result");
`endif

endmodule

// ===== test/modular_exponentiation_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Modular exponentiation testbench
// Sends base and exponent pairs through the input stream under a series of
// modulus settings, including one, zero and the largest value. Each result is
// checked against a square-and-multiply predictor. Both stream sides idle at
// random.
// ----------------------------------------------------------------------------
module modular_exponentiation_top_tb;

  import modexp_pkg::*;

  localparam int          CLK_PERIOD  = 8;
  localparam int unsigned CYCLE_LIMIT = 3_000_000;
  localparam int          DRAIN_WAIT  = 2300;

  logic                clk;
  logic                rst_n     = 1'b0;
  logic                cfg_we    = 1'b0;
  logic [FIELD_W-1:0]  cfg_wdata = '0;

  modexp_stream_if #(.data_t(in_item_t))  in_ch ();
  modexp_stream_if #(.data_t(out_item_t)) out_ch ();

  modular_exponentiation_top #(
    .WIDTH(32)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_if    (in_ch.sink),
    .out_if   (out_ch.source)
  );

  in_item_t          pending_items[$];
  out_item_t         expected_powers[$];
  logic [FIELD_W-1:0] modulus_now = 32'd1;
  int unsigned       failures    = 0;
  int unsigned       cycle_count = 0;
  int unsigned       send_gap    = 0;
  int unsigned       ready_stall = 0;
  bit                no_idling   = 1'b0;

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  initial begin
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
  end

  function automatic logic [63:0] mod_product(logic [63:0] a, logic [63:0] b,
                                              logic [FIELD_W-1:0] m);
    logic [63:0] full;
    full = a * b;
    if (m == 0) begin
      return {32'd0, full[31:0]};
    end
    return full % {32'd0, m};
  endfunction

  function automatic out_item_t predict_power(logic [FIELD_W-1:0] base,
                                              logic [FIELD_W-1:0] exponent,
                                              logic [FIELD_W-1:0] m);
    out_item_t   res;
    logic [63:0] acc;
    logic [63:0] sq;
    res.power_mod = 32'd1;
    if (exponent == 0) begin
      return res;
    end
    sq  = (m != 0) ? {32'd0, base} % {32'd0, m} : {32'd0, base};
    acc = (m == 1) ? 64'd0 : 64'd1;
    for (int i = 0; i < FIELD_W; i++) begin
      if (exponent[i]) begin
        acc = mod_product(acc, sq, m);
      end
      sq = mod_product(sq, sq, m);
    end
    res.power_mod = acc[31:0];
    return res;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idling || r < 60) begin
      return 0;
    end
    if (r < 90) begin
      return $urandom_range(1, 3);
    end
    if (r < 98) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(30, 150);
  endfunction

  function automatic logic [FIELD_W-1:0] pick_base(logic [FIELD_W-1:0] m);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 4) begin
      return '0;
    end
    if (r < 8) begin
      return 32'd1;
    end
    if (r < 12) begin
      return '1;
    end
    if (r < 24) begin
      return m + $urandom_range(0, 4) - 32'd2;
    end
    return $urandom();
  endfunction

  // Most exponents are short so that the run stays fast; some span all bits.
  function automatic logic [FIELD_W-1:0] pick_exponent();
    int unsigned r;
    int unsigned nbits;
    r = $urandom_range(0, 99);
    if (r < 5) begin
      return '0;
    end
    nbits = (r < 85) ? $urandom_range(1, 8) : $urandom_range(9, 32);
    return ($urandom() >> (32 - nbits)) | (32'd1 << (nbits - 1));
  endfunction

  always @(posedge clk) begin : drive_inputs
    in_item_t taken;
    logic     holding;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      holding = in_ch.valid && !in_ch.ready;
      if (in_ch.valid && in_ch.ready) begin
        taken = in_ch.data;
        expected_powers.push_back(predict_power(taken.base, taken.exponent, modulus_now));
      end
      if (!holding) begin
        if (send_gap != 0) begin
          send_gap--;
          in_ch.valid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          in_ch.valid <= 1'b1;
          in_ch.data  <= pending_items.pop_front();
          send_gap = pick_gap();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : check_results
    out_item_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_powers.size() == 0) begin
          $error("result transfer with no expectation pending: power_mod %h",
                 out_ch.data.power_mod);
          failures++;
        end else begin
          want = expected_powers.pop_front();
          if (out_ch.data.power_mod !== want.power_mod) begin
            $error("power_mod: expected %h, actual %h", want.power_mod,
                   out_ch.data.power_mod);
            failures++;
          end
        end
      end
      if (ready_stall != 0) begin
        ready_stall--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        ready_stall = pick_gap();
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL modular_exponentiation_top");
      $finish;
    end
  end

  task automatic wait_idle();
    while (pending_items.size() != 0 || in_ch.valid || expected_powers.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic write_modulus(logic [FIELD_W-1:0] value);
    wait_idle();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    modulus_now = value;
  endtask

  task automatic push_item(logic [FIELD_W-1:0] base, logic [FIELD_W-1:0] exponent);
    in_item_t item;
    item.base     = base;
    item.exponent = exponent;
    pending_items.push_back(item);
  endtask

  task automatic push_random(int count);
    for (int i = 0; i < count; i++) begin
      push_item(pick_base(modulus_now), pick_exponent());
    end
  endtask

  initial begin : stimulus
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // The modulus is one out of reset.
    push_item(32'd5, 32'd0);
    push_item(32'd0, 32'd0);
    push_item('1, '1);
    push_item(32'd7, 32'd1);

    write_modulus('1);
    push_item(32'd0, 32'd0);
    push_item(32'd0, 32'd5);
    push_item(32'd1, '1);
    push_item('1, 32'd1);
    push_item('1, 32'd2);
    push_item(32'd2, 32'd31);
    push_item(32'd3, '1);
    push_item(32'hFFFF_FFFE, 32'h8000_0000);
    push_item(32'h1234_5678, '1);

    // A modulus of zero wraps products to the field width.
    write_modulus('0);
    push_item(32'd2, 32'd31);
    push_item(32'd2, 32'd32);
    push_item(32'd3, '1);
    push_item('1, '1);
    push_item(32'h8000_0000, 32'd1);

    write_modulus(32'hFFFF_FFFB);
    push_random(31);
    write_modulus(32'd97);
    push_random(31);
    no_idling = 1'b1;
    write_modulus({1'b1, 31'($urandom())});
    push_random(31);
    no_idling = 1'b0;
    write_modulus(32'd2);
    push_random(31);
    write_modulus($urandom_range(3, 1000));
    push_random(31);
    write_modulus(32'd1);
    push_random(31);
    write_modulus(32'h8000_0000);
    push_random(31);
    write_modulus('0);
    push_random(31);
    write_modulus($urandom_range(1, 32'hFFFF_FFFF));
    push_random(31);

    wait_idle();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (failures == 0) begin
      $display("PASS modular_exponentiation_top");
    end else begin
      $display("FAIL modular_exponentiation_top");
    end
    $finish;
  end

endmodule
